/* rtl/running_median_filter_macros.svh */
// Assertion macros for the running median filter.
`ifndef RUNNING_MEDIAN_FILTER_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge, ignored while reset is asserted.
`define RMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define RMF_ASSERT(lbl, prop, msg)
`define RMF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/rmf_pkg.sv */
package rmf_pkg;

  // Window geometry
  localparam int WINDOW_LEN = 5;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int RANK_W     = $clog2(WINDOW_LEN);
  localparam int MID_RANK   = WINDOW_LEN / 2;

  // Sample format
  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [RANK_W-1:0]          rank_t;

endpackage

/* rtl/running_median_filter.sv */
// A request accepted is written into the window registers; the rank-compare
// network picks its median, which the output register captures for median_o.
// Throughput: one sample per cycle while out_stall_i is low; a stall backs up
// through both stages to in_stall_o and holds the sender.
// Reset (rst_ni low, asynchronous): window cleared to zero, write slot to zero,
// both pipeline stages empty.
`include "running_median_filter_macros.svh"

module running_median_filter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rmf_pkg::sample_t sample_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rmf_pkg::sample_t median_o
);
  import rmf_pkg::*;

  localparam slot_t LAST_SLOT = slot_t'(WINDOW_LEN - 1);
  localparam rank_t MID       = rank_t'(MID_RANK);

  sample_t hist_q [WINDOW_LEN];
  slot_t   write_slot_q;
  slot_t   slot_d;
  logic    win_valid_q;
  logic    out_valid_q;
  sample_t median_q;
  sample_t median_d;
  logic    out_ready;
  logic    win_ready;
  logic    in_acc;
  rank_t   rank [WINDOW_LEN];

  // Handshake: output stage frees when taken, window stage when it moves on
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign win_ready  = !win_valid_q || out_ready;
  assign in_stall_o = !win_ready;
  assign in_acc     = in_valid_i && win_ready;

  // Advance the write slot with wrap
  assign slot_d = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;

  // Rank each entry: smaller values first, equal values ordered by slot
  always_comb begin
    logic [WINDOW_LEN-1:0] below;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      below = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (j != i) begin
          below[j] = (hist_q[j] < hist_q[i]) || ((hist_q[j] == hist_q[i]) && (j < i));
        end
      end
      rank[i] = rank_t'($countones(below));
    end
  end

  // Pick the entry whose rank is the middle one
  always_comb begin
    median_d = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      median_d = median_d | ((rank[i] == MID) ? hist_q[i] : '0);
    end
  end

  // Write the sample into the window and mark the window stage full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        hist_q[i] <= '0;
      end
      write_slot_q <= '0;
      win_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        hist_q[write_slot_q] <= sample_i;
        write_slot_q         <= slot_d;
      end
      if (win_ready) begin
        win_valid_q <= in_acc;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= win_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && win_valid_q) begin
      median_q <= median_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  `RMF_ASSERT_ALWAYS(a_slot_range, (write_slot_q <= LAST_SLOT), "write slot out of range")
  `RMF_ASSERT(a_acc_fills_window, (in_acc |=> win_valid_q), "accepted request lost")
  `RMF_ASSERT(a_slot_step, (in_acc |=> (write_slot_q == $past(slot_d))), "slot did not advance")
  `RMF_ASSERT(a_slot_hold, (!in_acc |=> $stable(write_slot_q)), "slot moved without request")
  `RMF_ASSERT(a_win_to_out, ((win_valid_q && out_ready) |=> out_valid_q), "result dropped")

endmodule

/* bench/running_median_filter_test.sv */
`timescale 1ns / 100ps

module running_median_filter_test;
  import rmf_pkg::*;

  // Tracks the sample window and holds the medians still owed by the block
  class median_scoreboard;
    sample_t     sample_window[WINDOW_LEN];
    int unsigned next_slot;
    sample_t     pending_medians[$];
    int unsigned failures;

    function new();
      foreach (sample_window[i]) sample_window[i] = '0;
      next_slot = 0;
      failures  = 0;
    endfunction

    // Store an accepted sample and queue the median it produces
    function void note_sample(sample_t s);
      sample_t ranked[WINDOW_LEN];
      sample_t key;
      int      j;
      sample_window[next_slot] = s;
      next_slot = (next_slot + 1) % WINDOW_LEN;
      ranked = sample_window;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        key = ranked[i];
        j   = i - 1;
        while (j >= 0 && ranked[j] > key) begin
          ranked[j + 1] = ranked[j];
          j--;
        end
        ranked[j + 1] = key;
      end
      pending_medians.push_back(ranked[MID_RANK]);
    endfunction

    // Compare a delivered median against the oldest one owed
    function void check_median(sample_t m);
      sample_t want;
      if (pending_medians.size() == 0) begin
        $error("median: unexpected result, actual %0d", m);
        failures++;
      end else begin
        want = pending_medians.pop_front();
        if (m !== want) begin
          $error("median mismatch: expected %0d, actual %0d", want, m);
          failures++;
        end
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 230;

  logic    clk_i       = 1'b0;
  logic    rst_ni;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  sample_t sample_i    = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  sample_t median_o;

  median_scoreboard board = new();
  int unsigned      sender_idle_pct   = 0;
  int unsigned      receiver_stall_pct = 0;
  int unsigned      idle_cycles       = 0;

  // Extremes, start-up against the zeroed window, runs of equal values
  sample_t directed_samples[24] = '{
    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
    16'sh8000, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh0001,
    16'sh0001, 16'sh0001, 16'sh0001, 16'sh8000, 16'sh7FFF, 16'sh8000,
    16'sh7FFF, 16'sh8000, 16'shFFFE, 16'sh0002, 16'sh5555, 16'shAAAA
  };

  running_median_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .median_o    (median_o)
  );

  always #6 clk_i = ~clk_i;

  // Observe both channels on the edge, then pick the next output stall
  always @(posedge clk_i) begin
    logic moved;
    moved = 1'b0;
    if (in_valid_i && !in_stall_o) begin
      board.note_sample(sample_i);
      moved = 1'b1;
    end
    if (out_valid_o && !out_stall_i) begin
      board.check_median(median_o);
      moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // End the run when nothing moves for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until taken
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every owed median has come out
  task automatic drain_medians();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_medians.size() != 0);
  endtask

  // Mostly full-range values, plus clusters that force ties and extremes
  function automatic sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return sample_t'($urandom);
    if (pick < 85) return sample_t'($urandom_range(8)) - sample_t'(4);
    if (pick < 93) return sample_t'(16'sh7FFF - $urandom_range(2));
    return sample_t'(16'sh8000 + $urandom_range(2));
  endfunction

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples at full rate
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    drain_medians();

    // Random phases: full rate, idle sender, stalling receiver, both, full rate
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
        3: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
        default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
      repeat (PHASE_ITEMS) send_sample(random_sample());
      drain_medians();
    end

    receiver_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (board.failures == 0 && board.pending_medians.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* running_median_filter.f */
+incdir+rtl
rtl/rmf_pkg.sv
rtl/running_median_filter.sv
bench/running_median_filter_test.sv
